// File: rtl/fcsg_pkg.sv
// Package: shared types and constants of the filled circle span generator.
`timescale 1ns / 1ps

package fcsg_pkg;

	localparam int COORD_W   = 12;
	localparam int RADIUS_W  = 6;
	localparam int ROW_W     = 13;
	localparam int XS_W      = 11;
	localparam int LEN_W     = 7;
	localparam int SCREEN_W  = 12;
	localparam int ROOT_W    = 11;
	localparam int ROOT_STEPS = 6;
	localparam int SPAN_MAX  = 64;
	localparam int JOBQ_DEPTH = 2;

	localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1 << (2 * (ROOT_STEPS - 1)));

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd600;

	typedef struct packed {
		logic signed [ROW_W-1:0]   row;
		logic signed [COORD_W-1:0] cx;
		logic [ROOT_W-1:0]         radicand;
		logic                      visible;
		logic                      last;
	} job_t;

	typedef struct packed {
		logic signed [ROW_W-1:0] row;
		logic [XS_W-1:0]         x_start;
		logic [LEN_W-1:0]        span_len;
		logic                    visible;
		logic                    last;
	} span_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROOT  = 3'b010,
		ST_WRITE = 3'b100
	} back_state_t;

endpackage

// File: rtl/fcsg_front.sv
// Front end: takes circle requests and issues one row job per span.
`timescale 1ns / 1ps

module fcsg_front import fcsg_pkg::*; #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic [RADIUS_W-1:0]       radius,
	input  logic [SCREEN_W-1:0]       screen_height,
	output logic                      job_push,
	output job_t                      job,
	input  logic                      job_full
);

	logic                      busy_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RADIUS_W-1:0]       r_q;
	logic [RADIUS_W:0]         idx_q;

	logic [RADIUS_W-1:0]       r_sat;
	logic signed [ROW_W:0]     row_w;
	logic signed [RADIUS_W+1:0] d;
	logic [RADIUS_W+1:0]       d_abs;
	logic [2*RADIUS_W-1:0]     rr;
	logic [2*RADIUS_W-1:0]     dd;
	logic [2*RADIUS_W-1:0]     diff;
	logic                      is_last;

	assign r_sat = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;

	always_comb begin
		row_w   = (ROW_W + 1)'(cy_q) - $signed({{(ROW_W + 1 - RADIUS_W){1'b0}}, r_q})
			+ $signed({{(ROW_W - RADIUS_W){1'b0}}, idx_q});
		d       = $signed({2'b00, r_q}) - $signed({1'b0, idx_q});
		d_abs   = d[RADIUS_W+1] ? (RADIUS_W + 2)'(-d) : d;
		rr      = {{RADIUS_W{1'b0}}, r_q} * {{RADIUS_W{1'b0}}, r_q};
		dd      = {{RADIUS_W{1'b0}}, d_abs[RADIUS_W-1:0]}
			* {{RADIUS_W{1'b0}}, d_abs[RADIUS_W-1:0]};
		diff    = rr - dd;
		is_last = (r_q == '0) || (idx_q == ({r_q, 1'b0} - (RADIUS_W + 1)'(1)));
	end

	always_comb begin
		job.row      = row_w[ROW_W-1:0];
		job.cx       = cx_q;
		job.radicand = diff[ROOT_W-1:0];
		job.visible  = !row_w[ROW_W-1] && (row_w[SCREEN_W-1:0] < screen_height);
		job.last     = is_last;
	end

	assign job_push = busy_q && !job_full;
	assign full     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q) begin
			if (push) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end else if (job_push) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + (RADIUS_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && push) begin
			cx_q <= center_x;
			cy_q <= center_y;
			r_q  <= r_sat;
		end
	end

endmodule

// File: rtl/fcsg_job_fifo.sv
// Two-entry queue of row jobs between front and back.
`timescale 1ns / 1ps

module fcsg_job_fifo import fcsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t rd_job,
	output logic empty
);

	localparam int PTR_W = $clog2(JOBQ_DEPTH);

	job_t             mem_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full   = (count_q == (PTR_W + 1)'(JOBQ_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: rtl/fcsg_back.sv
// Back end: iterative square root, span clipping and result register.
`timescale 1ns / 1ps

module fcsg_back import fcsg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SCREEN_W-1:0] screen_width,
	input  job_t                job,
	input  logic                job_empty,
	output logic                job_pop,
	output span_t               span,
	output logic                empty,
	input  logic                pop
);

	back_state_t               state_q;
	logic [ROOT_W-1:0]         rem_q;
	logic [ROOT_W:0]           res_q;
	logic [ROOT_W-1:0]         bit_q;
	logic signed [ROW_W-1:0]   row_q;
	logic signed [COORD_W-1:0] cx_q;
	logic                      vis_q;
	logic                      last_q;
	span_t                     out_q;
	logic                      out_valid_q;

	logic [ROOT_W:0]           trial;
	logic                      out_free;
	logic signed [13:0]        half_s;
	logic signed [13:0]        xs0;
	logic signed [13:0]        xs1;
	logic signed [13:0]        len0;
	logic signed [13:0]        len1;
	logic signed [13:0]        len2;
	logic signed [13:0]        sw_s;
	span_t                     span_new;

	assign trial    = res_q + {1'b0, bit_q};
	assign out_free = !out_valid_q || pop;
	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign span     = out_q;
	assign empty    = !out_valid_q;

	always_comb begin
		half_s = $signed(14'(res_q));
		sw_s   = $signed(14'(screen_width));
		xs0    = 14'(cx_q) - half_s;
		len0   = half_s + half_s;
		if (xs0 < 0) begin
			len1 = len0 + xs0;
			xs1  = '0;
		end else begin
			len1 = len0;
			xs1  = xs0;
		end
		if (xs1 + len1 >= sw_s) begin
			len2 = sw_s - xs1;
		end else begin
			len2 = len1;
		end
		if (len2 < 0) begin
			len2 = '0;
		end
		span_new.row      = row_q;
		span_new.visible  = vis_q;
		span_new.last     = last_q;
		span_new.x_start  = vis_q ? xs1[XS_W-1:0] : '0;
		span_new.span_len = vis_q ? len2[LEN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_q == ROOT_W'(1)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q  <= job.radicand;
				res_q  <= '0;
				bit_q  <= ROOT_BIT_INIT;
				row_q  <= job.row;
				cx_q   <= job.cx;
				vis_q  <= job.visible;
				last_q <= job.last;
			end
			ST_ROOT: begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= rem_q - trial[ROOT_W-1:0];
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_WRITE: begin
				if (out_free) begin
					out_q <= span_new;
				end
			end
			default: begin
				bit_q <= bit_q;
			end
		endcase
	end

	a_invisible_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.visible) |-> (out_q.x_start == '0 && out_q.span_len == '0))
		else $error("invisible span carries pixels");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.span_len <= LEN_W'(SPAN_MAX)))
		else $error("span length beyond circle diameter");

	a_right_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.span_len != '0)
		|-> ((SCREEN_W'(out_q.x_start) + SCREEN_W'(out_q.span_len)) <= screen_width))
		else $error("span runs past right screen edge");

endmodule

// File: rtl/filled_circle_span_generator.sv
// Top level: filled circle span generator with configuration registers.
`timescale 1ns / 1ps

// Each circle request yields 2*radius spans (one span for radius 0), the radius
// saturated at MAX_RADIUS, delivered in row order with last set on the final one.
// Each span passes in order through a load state, the 6-step square root in the
// back end and a clip/write state that waits while the output register is full.
// The input shows full while a circle's rows are being issued.
// screen_width and screen_height reset to 800 and 600; the user must write them
// only while the block is idle, which the block itself does not enforce.

module filled_circle_span_generator import fcsg_pkg::*; #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [SCREEN_W-1:0]       wr_data,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic [RADIUS_W-1:0]       radius,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ROW_W-1:0]   row,
	output logic [XS_W-1:0]           x_start,
	output logic [LEN_W-1:0]          span_len,
	output logic                      visible,
	output logic                      last
);

	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;

	logic  front_push;
	job_t  front_job;
	logic  jobq_full;
	logic  jobq_pop;
	job_t  jobq_job;
	logic  jobq_empty;
	span_t span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= wr_data;
				REG_SCREEN_HEIGHT: screen_height_q <= wr_data;
				default:           screen_width_q  <= screen_width_q;
			endcase
		end
	end

	fcsg_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.screen_height(screen_height_q),
		.job_push     (front_push),
		.job          (front_job),
		.job_full     (jobq_full)
	);

	fcsg_job_fifo u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_push),
		.wr_job(front_job),
		.full  (jobq_full),
		.pop   (jobq_pop),
		.rd_job(jobq_job),
		.empty (jobq_empty)
	);

	fcsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.screen_width(screen_width_q),
		.job         (jobq_job),
		.job_empty   (jobq_empty),
		.job_pop     (jobq_pop),
		.span        (span),
		.empty       (empty),
		.pop         (pop)
	);

	assign row      = span.row;
	assign x_start  = span.x_start;
	assign span_len = span.span_len;
	assign visible  = span.visible;
	assign last     = span.last;

endmodule

// File: tb/sv/tb_filled_circle_span_generator.sv
// Testbench: filled circle span generator, self-checking against an internal span predictor.
`timescale 1ns / 1ps

module tb_filled_circle_span_generator import fcsg_pkg::*;;

	localparam int MAX_R       = 32;
	localparam int WATCHDOG    = 20000;
	localparam int SETTLE      = 32;
	localparam int HOLD_CYCLES = 2500;
	localparam int PRINT_MAX   = 30;

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [1:0]                wr_index;
	logic [SCREEN_W-1:0]       wr_data;
	logic                      push;
	logic                      full;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [RADIUS_W-1:0]       radius;
	logic                      empty;
	logic                      pop;
	logic signed [ROW_W-1:0]   row;
	logic [XS_W-1:0]           x_start;
	logic [LEN_W-1:0]          span_len;
	logic                      visible;
	logic                      last;

	span_t pending_spans[$];
	int    model_width;
	int    model_height;
	int    errors;
	int    circles_sent;
	int    spans_checked;
	int    settings_used;
	int    in_accepted;
	int    idle_cycles;
	int    rx_hold_req;
	int    rx_hold_left;
	int    rx_gap_left;
	bit    no_idle;

	filled_circle_span_generator #(
		.MAX_RADIUS(MAX_R)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.push(push),
		.full(full),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.empty(empty),
		.pop(pop),
		.row(row),
		.x_start(x_start),
		.span_len(span_len),
		.visible(visible),
		.last(last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int root_floor(int v);
		int s;
		s = 0;
		while ((s + 1) * (s + 1) <= v)
			s++;
		return s;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic predict_spans(int cx, int cy, int rad);
		int    r;
		int    count;
		int    i;
		int    rw;
		int    d;
		int    half;
		int    xs;
		int    len;
		bit    vis;
		span_t s;
		r = (rad > MAX_R) ? MAX_R : rad;
		count = (r == 0) ? 1 : 2 * r;
		for (i = 0; i < count; i++) begin
			rw = cy - r + i;
			xs = 0;
			len = 0;
			vis = (rw >= 0) && (rw < model_height);
			if (vis) begin
				d = r - i;
				half = root_floor(r * r - d * d);
				len = 2 * half;
				xs = cx - half;
				if (xs < 0) begin
					len += xs;
					xs = 0;
				end
				if (xs + len >= model_width)
					len = model_width - xs;
				if (len < 0)
					len = 0;
			end
			s.row = rw[ROW_W-1:0];
			s.x_start = xs[XS_W-1:0];
			s.span_len = len[LEN_W-1:0];
			s.visible = vis;
			s.last = (i == count - 1);
			pending_spans.push_back(s);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= PRINT_MAX)
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	// request capture, span check and activity count
	always @(posedge clk) begin
		span_t want;
		if (arst_n) begin
			if (push && !full) begin
				predict_spans(int'(center_x), int'(center_y), int'(radius));
				in_accepted++;
				circles_sent++;
			end
			if (pop && !empty) begin
				spans_checked++;
				if (pending_spans.size() == 0) begin
					report_mismatch("span with none pending, row", int'(row), 0);
				end else begin
					want = pending_spans.pop_front();
					if (row !== want.row)
						report_mismatch("row", int'(row), int'(want.row));
					if (x_start !== want.x_start)
						report_mismatch("x_start", int'(x_start), int'(want.x_start));
					if (span_len !== want.span_len)
						report_mismatch("span_len", int'(span_len), int'(want.span_len));
					if (visible !== want.visible)
						report_mismatch("visible", int'(visible), int'(want.visible));
					if (last !== want.last)
						report_mismatch("last", int'(last), int'(want.last));
				end
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG);
		$display("watchdog: no handshake for %0d cycles", WATCHDOG);
		$display("tb_filled_circle_span_generator failed");
		$finish;
	end

	// result side: random pop gaps plus an optional long hold-off
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				rx_hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else if (rx_gap_left > 0) begin
				rx_gap_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				rx_gap_left = pick_gap();
			end
		end
	end

	task automatic send_circle(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
			logic [RADIUS_W-1:0] r);
		int gap;
		int seen;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seen = in_accepted;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		push <= 1'b1;
		do
			@(negedge clk);
		while (in_accepted == seen);
	endtask

	task automatic send_random_circle();
		int p;
		int v;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RADIUS_W-1:0]       r;
		p = $urandom_range(0, 99);
		if (p < 45)
			r = RADIUS_W'($urandom_range(0, 8));
		else if (p < 80)
			r = RADIUS_W'($urandom_range(9, 32));
		else
			r = RADIUS_W'($urandom_range(33, 63));
		if ($urandom_range(0, 99) < 70) begin
			v = int'($urandom_range(0, model_width + 80)) - 40;
			cx = v[COORD_W-1:0];
		end else begin
			cx = COORD_W'($urandom_range(0, 4095));
		end
		if ($urandom_range(0, 99) < 70) begin
			v = int'($urandom_range(0, model_height + 80)) - 40;
			cy = v[COORD_W-1:0];
		end else begin
			cy = COORD_W'($urandom_range(0, 4095));
		end
		send_circle(cx, cy, r);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (pending_spans.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_screen(logic [1:0] idx, logic [SCREEN_W-1:0] val);
		wr_index <= idx;
		wr_data <= val;
		wr_en <= 1'b1;
		if (idx == REG_SCREEN_WIDTH)
			model_width = int'(val);
		else if (idx == REG_SCREEN_HEIGHT)
			model_height = int'(val);
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_screen(logic [SCREEN_W-1:0] w, logic [SCREEN_W-1:0] h);
		wait_drain();
		write_screen(REG_SCREEN_WIDTH, w);
		write_screen(REG_SCREEN_HEIGHT, h);
		settings_used++;
	endtask

	task automatic test_directed();
		send_circle(12'sd0, 12'sd0, 6'd0);
		send_circle(-12'sd2048, 12'sd300, 6'd0);
		send_circle(12'sd2047, 12'sd300, 6'd0);
		send_circle(12'sd100, -12'sd1, 6'd0);
		send_circle(12'sd100, 12'sd600, 6'd0);
		send_circle(12'sd400, 12'sd300, 6'd1);
		send_circle(12'sd400, 12'sd300, 6'd32);
		send_circle(12'sd400, 12'sd300, 6'd33);
		send_circle(12'sd400, 12'sd300, 6'd63);
		send_circle(-12'sd2048, 12'sd2047, 6'd63);
		send_circle(-12'sd2048, -12'sd2048, 6'd32);
		send_circle(12'sd2047, 12'sd300, 6'd32);
		send_circle(-12'sd40, 12'sd300, 6'd32);
		send_circle(-12'sd10, 12'sd300, 6'd20);
		send_circle(12'sd790, 12'sd300, 6'd20);
		send_circle(12'sd400, -12'sd5, 6'd10);
		send_circle(12'sd400, 12'sd595, 6'd10);
		send_circle(12'sh555, 12'sh2AA, 6'h2A);
		send_circle(12'shAAA, 12'shAAA, 6'h15);
		send_circle(12'sd800, 12'sd300, 6'd5);
		// sender pauses until every span is back
		wait_drain();
	endtask

	task automatic test_screen_extremes();
		logic [SCREEN_W-1:0] widths[6]  = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd37, 12'd2048};
		logic [SCREEN_W-1:0] heights[6] = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd2048, 12'd1};
		int k;
		int n;
		for (k = 0; k < 6; k++) begin
			set_screen(widths[k], heights[k]);
			send_circle(12'sd0, 12'sd0, 6'd3);
			for (n = 0; n < 9; n++)
				send_random_circle();
		end
		set_screen(12'd800, 12'd600);
	endtask

	task automatic test_output_stall();
		int n;
		rx_hold_req = HOLD_CYCLES;
		for (n = 0; n < 20; n++)
			send_circle(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 700)),
				RADIUS_W'($urandom_range(4, 16)));
		wait_drain();
	endtask

	task automatic test_random_mix();
		int ph;
		int n;
		for (ph = 0; ph < 5; ph++) begin
			if (ph == 0)
				set_screen(12'd800, 12'd600);
			else
				set_screen(SCREEN_W'($urandom_range(1, 2048)),
					SCREEN_W'($urandom_range(1, 2048)));
			no_idle = (ph == 3);
			for (n = 0; n < 46; n++) begin
				if ($urandom_range(0, 99) < 3)
					wait_drain();
				send_random_circle();
			end
			no_idle = 1'b0;
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SCREEN_WIDTH;
		wr_data = '0;
		push = 1'b0;
		center_x = '0;
		center_y = '0;
		radius = '0;
		model_width = int'(SCREEN_WIDTH_RST);
		model_height = int'(SCREEN_HEIGHT_RST);
		errors = 0;
		circles_sent = 0;
		spans_checked = 0;
		settings_used = 1;
		in_accepted = 0;
		idle_cycles = 0;
		rx_hold_req = 0;
		rx_hold_left = 0;
		rx_gap_left = 0;
		no_idle = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_screen_extremes();
		test_output_stall();
		test_random_mix();

		$display("Covered %0d circles and %0d spans over %0d screen settings", circles_sent,
			spans_checked, settings_used);
		$display("Included zero and saturated radii, clipping on every side and a long output stall");
		if (errors == 0)
			$display("tb_filled_circle_span_generator passed");
		else
			$display("tb_filled_circle_span_generator failed");
		$finish;
	end

endmodule

// File: files.f
rtl/fcsg_pkg.sv
rtl/fcsg_front.sv
rtl/fcsg_job_fifo.sv
rtl/fcsg_back.sv
rtl/filled_circle_span_generator.sv
tb/sv/tb_filled_circle_span_generator.sv
